FILE: design/wfg_pkg.sv
// Package for the wait-for graph deadlock detector.
// Holds sizes, action and register codes shared by the modulo unit and the top level.
// No dependencies.
`default_nettype none
package wfg_pkg;

  localparam int MAX_THREADS = 16;
  localparam int MAX_EDGES   = 8;
  localparam int LOCK_LIMIT  = 1000;

  localparam int SLOT_W  = $clog2(MAX_THREADS);
  localparam int EIDX_W  = $clog2(MAX_EDGES);
  localparam int FILL_W  = $clog2(MAX_EDGES + 1);
  localparam int SP_W    = $clog2(MAX_THREADS + 1);
  localparam int TC_W    = 5;
  localparam int TXN_W   = 32;
  localparam int LOCK_W  = 16;
  localparam int EADDR_W = SLOT_W + EIDX_W;

  // modulo unit digit size: bits folded in per cycle
  localparam int MOD_DIGIT = 8;
  localparam int MOD_STEPS = TXN_W / MOD_DIGIT;

  localparam logic [1:0] ACT_ADD    = 2'd0;
  localparam logic [1:0] ACT_CLEAR  = 2'd1;
  localparam logic [1:0] ACT_DETECT = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  localparam logic CFG_THREAD_COUNT = 1'b0;
  localparam logic CFG_DETECT_EN    = 1'b1;

endpackage
`default_nettype wire

FILE: design/wait_for_graph_deadlock_detector.sv
// Top level of the wait-for graph deadlock detector: slot tables, edge memory,
// search stack and the sequencer. Depends on wfg_pkg and wfg_mod.
//
//   channel | direction | handshake             | payload
//   in      | input     | in_valid / in_ready   | action, txn_id, target_txn, has_target, lock_count
//   out     | output    | out_valid / out_ready | status, deadlock, abort_valid, victim_txn
//   cfg     | input     | cfg_we (no wait)      | cfg_index, cfg_wdata
//
// One beat at a time. Add and clear pass the id modulo thread_count through the shared
// remainder unit, 8 bits at a time. Detect walks each edge with an edge read, one remainder
// pass and a slot read, and pops each finished node, so the edge walk through the remainder
// unit sets its length.
// Reset (synchronous, rst_n low) clears slot valid bits, edge fill counts and the sequencer.
// in_ready is high only in idle; a finished result waits in the output register.
`default_nettype none
module wait_for_graph_deadlock_detector
  import wfg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        in_action,
  input  wire logic [TXN_W-1:0]  in_txn_id,
  input  wire logic [TXN_W-1:0]  in_target_txn,
  input  wire logic              in_has_target,
  input  wire logic [LOCK_W-1:0] in_lock_count,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic                   out_status,
  output logic                   out_deadlock,
  output logic                   out_abort_valid,
  output logic [TXN_W-1:0]       out_victim_txn,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [TC_W-1:0]   cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_MOD_ID, S_CHK0, S_LOOP, S_POP, S_EDGE_RD, S_EDGE_MOD, S_EDGE_CHK, S_FIN
  } state_t;

  state_t              state_r;

  // configuration
  logic [TC_W-1:0]     thread_count_r;
  logic                detect_en_r;
  logic [TC_W-1:0]     active_tc;

  // latched item
  logic [1:0]          action_r;
  logic [TXN_W-1:0]    id_r;
  logic [TXN_W-1:0]    tgt_in_r;
  logic                has_t_r;
  logic [LOCK_W-1:0]   locks_in_r;

  // slot tables
  logic [MAX_THREADS-1:0] slot_valid_r;
  logic [FILL_W-1:0]      edge_fill_r [MAX_THREADS];
  logic [TXN_W+LOCK_W-1:0] slot_mem [MAX_THREADS];
  logic [TXN_W+LOCK_W-1:0] slot_q;
  logic [SLOT_W-1:0]      slot_raddr;
  logic [SLOT_W-1:0]      slot_rslot_r;
  logic                   slot_we;
  logic [SLOT_W-1:0]      slot_waddr;
  logic [TXN_W-1:0]       rd_txn;
  logic [LOCK_W-1:0]      rd_locks;
  logic                   rd_current;

  // edge memory
  logic [TXN_W-1:0]     edge_mem [MAX_THREADS*MAX_EDGES];
  logic [TXN_W-1:0]     edge_q;
  logic [EADDR_W-1:0]   edge_raddr;
  logic                 edge_we;
  logic [EADDR_W-1:0]   edge_waddr;

  // search state
  logic [MAX_THREADS-1:0] visited_r;
  logic [MAX_THREADS-1:0] on_path_r;
  logic [SLOT_W-1:0]      stk_slot_r [MAX_THREADS];
  logic [FILL_W-1:0]      stk_edge_r [MAX_THREADS];
  logic [SP_W-1:0]        sp_r;
  logic [SLOT_W-1:0]      top;
  logic [SLOT_W-1:0]      top_slot;
  logic [FILL_W-1:0]      top_edge;
  logic                   loop_r;
  logic                   onloop_r;
  logic                   have_ls_r;
  logic [SLOT_W-1:0]      loopstart_r;
  logic [LOCK_W-1:0]      min_locks_r;
  logic                   have_victim_r;
  logic [TXN_W-1:0]       victim_r;
  logic [TXN_W-1:0]       edge_tgt_r;
  logic                   status_r;
  logic                   pop_now;

  // shared remainder unit
  logic                 mod_start;
  logic [TXN_W-1:0]     mod_value;
  logic                 mod_done;
  logic [SLOT_W-1:0]    mod_rem;

  // output register
  logic                 out_valid_r;
  logic                 out_status_r;
  logic                 out_deadlock_r;
  logic                 out_abort_r;
  logic [TXN_W-1:0]     out_victim_r;
  logic                 fin_fire;

  logic                 accept;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // load the output register once it is free or being drained
  assign fin_fire = (state_r == S_FIN) && (!out_valid_r || out_ready);

  // zero acts as one, anything above the slot count acts as the slot count
  always_comb begin
    if (thread_count_r == '0) begin
      active_tc = TC_W'(1);
    end else if (thread_count_r > TC_W'(MAX_THREADS)) begin
      active_tc = TC_W'(MAX_THREADS);
    end else begin
      active_tc = thread_count_r;
    end
  end

  assign top      = SLOT_W'(sp_r - SP_W'(1));
  assign top_slot = stk_slot_r[top];
  assign top_edge = stk_edge_r[top];
  assign pop_now  = loop_r || (top_edge >= edge_fill_r[top_slot]) ||
                    (top_edge >= FILL_W'(MAX_EDGES));

  // start the remainder on the item id, or on an edge target once it is read
  assign mod_start = (accept && detect_en_r && (in_action != ACT_NONE)) ||
                     (state_r == S_EDGE_RD);
  assign mod_value = (state_r == S_EDGE_RD) ? edge_q : in_txn_id;

  wfg_mod u_mod (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mod_start),
    .value   (mod_value),
    .divisor (active_tc),
    .done    (mod_done),
    .rem     (mod_rem)
  );

  // slot read address per step
  always_comb begin
    unique case (state_r)
      S_MOD_ID:   slot_raddr = mod_rem;
      S_EDGE_MOD: slot_raddr = mod_rem;
      S_LOOP:     slot_raddr = top_slot;
      default:    slot_raddr = '0;
    endcase
  end

  assign slot_we    = (state_r == S_MOD_ID) && mod_done && (action_r == ACT_ADD);
  assign slot_waddr = mod_rem;
  assign edge_raddr = {top_slot, top_edge[EIDX_W-1:0]};
  assign edge_we    = slot_we && has_t_r && (edge_fill_r[mod_rem] < FILL_W'(MAX_EDGES));
  assign edge_waddr = {mod_rem, edge_fill_r[mod_rem][EIDX_W-1:0]};

  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= {id_r, locks_in_r};
    end
    slot_q       <= slot_mem[slot_raddr];
    slot_rslot_r <= slot_raddr;
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= tgt_in_r;
    end
    edge_q <= edge_mem[edge_raddr];
  end

  // a slot that is not valid reads with zero locks and never matches
  assign rd_txn     = slot_q[TXN_W+LOCK_W-1:LOCK_W];
  assign rd_locks   = slot_valid_r[slot_rslot_r] ? slot_q[LOCK_W-1:0] : '0;
  assign rd_current = slot_valid_r[slot_rslot_r] &&
                      (rd_txn == ((state_r == S_CHK0) ? id_r : edge_tgt_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      thread_count_r <= TC_W'(MAX_THREADS);
      detect_en_r    <= 1'b1;
      slot_valid_r   <= '0;
      for (int i = 0; i < MAX_THREADS; i++) begin
        edge_fill_r[i] <= '0;
      end
      visited_r      <= '0;
      on_path_r      <= '0;
      sp_r           <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_THREAD_COUNT: thread_count_r <= cfg_wdata;
          CFG_DETECT_EN:    detect_en_r    <= cfg_wdata[0];
        endcase
      end
      if (fin_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            action_r      <= in_action;
            id_r          <= in_txn_id;
            tgt_in_r      <= in_target_txn;
            has_t_r       <= in_has_target;
            locks_in_r    <= in_lock_count;
            status_r      <= 1'b0;
            loop_r        <= 1'b0;
            onloop_r      <= 1'b0;
            have_ls_r     <= 1'b0;
            have_victim_r <= 1'b0;
            min_locks_r   <= LOCK_W'(LOCK_LIMIT);
            victim_r      <= '0;
            visited_r     <= '0;
            on_path_r     <= '0;
            sp_r          <= '0;
            // disabled block or unused code: answer with all zero
            if (detect_en_r && (in_action != ACT_NONE)) begin
              state_r <= S_MOD_ID;
            end else begin
              state_r <= S_FIN;
            end
          end
        end

        S_MOD_ID: begin
          if (mod_done) begin
            unique case (action_r)
              ACT_ADD: begin
                slot_valid_r[mod_rem] <= 1'b1;
                if (has_t_r) begin
                  if (edge_fill_r[mod_rem] < FILL_W'(MAX_EDGES)) begin
                    edge_fill_r[mod_rem] <= edge_fill_r[mod_rem] + FILL_W'(1);
                  end else begin
                    status_r <= 1'b1;
                  end
                end
                state_r <= S_FIN;
              end
              ACT_CLEAR: begin
                slot_valid_r[mod_rem] <= 1'b0;
                edge_fill_r[mod_rem]  <= '0;
                state_r <= S_FIN;
              end
              default: begin
                visited_r[mod_rem] <= 1'b1;
                state_r <= S_CHK0;
              end
            endcase
          end
        end

        S_CHK0: begin
          // push the start only if its slot holds it
          if (rd_current) begin
            on_path_r[slot_rslot_r] <= 1'b1;
            stk_slot_r[0]           <= slot_rslot_r;
            stk_edge_r[0]           <= '0;
            sp_r                    <= SP_W'(1);
            state_r                 <= S_LOOP;
          end else begin
            state_r <= S_FIN;
          end
        end

        S_LOOP: begin
          if (sp_r == '0) begin
            state_r <= S_FIN;
          end else if (pop_now) begin
            state_r <= S_POP;
          end else begin
            state_r <= S_EDGE_RD;
          end
        end

        S_POP: begin
          // unwind one node; while on the loop, track the fewest locks
          on_path_r[top_slot] <= 1'b0;
          if (loop_r && onloop_r && (rd_locks < min_locks_r)) begin
            min_locks_r   <= rd_locks;
            victim_r      <= rd_txn;
            have_victim_r <= 1'b1;
          end
          if (have_ls_r && (top_slot == loopstart_r)) begin
            onloop_r <= 1'b0;
          end
          sp_r    <= sp_r - SP_W'(1);
          state_r <= S_LOOP;
        end

        S_EDGE_RD: begin
          edge_tgt_r      <= edge_q;
          stk_edge_r[top] <= top_edge + FILL_W'(1);
          state_r         <= S_EDGE_MOD;
        end

        S_EDGE_MOD: begin
          if (mod_done) begin
            state_r <= S_EDGE_CHK;
          end
        end

        S_EDGE_CHK: begin
          if (on_path_r[slot_rslot_r] && rd_current) begin
            loop_r      <= 1'b1;
            onloop_r    <= 1'b1;
            loopstart_r <= slot_rslot_r;
            have_ls_r   <= 1'b1;
          end else if (!visited_r[slot_rslot_r] && rd_current &&
                       (sp_r != SP_W'(MAX_THREADS))) begin
            visited_r[slot_rslot_r]       <= 1'b1;
            on_path_r[slot_rslot_r]       <= 1'b1;
            stk_slot_r[sp_r[SLOT_W-1:0]]  <= slot_rslot_r;
            stk_edge_r[sp_r[SLOT_W-1:0]]  <= '0;
            sp_r                          <= sp_r + SP_W'(1);
          end
          state_r <= S_LOOP;
        end

        S_FIN: begin
          // hold until the output register is free
          if (fin_fire) begin
            out_status_r   <= status_r;
            out_deadlock_r <= loop_r;
            // the victim was current when pushed and nothing writes during a search
            out_abort_r    <= loop_r && have_victim_r;
            out_victim_r   <= (loop_r && have_victim_r) ? victim_r : '0;
            state_r        <= S_IDLE;
          end
        end

        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_deadlock    = out_deadlock_r;
  assign out_abort_valid = out_abort_r;
  assign out_victim_txn  = out_victim_r;

`ifndef SYNTHESIS
  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= SP_W'(MAX_THREADS))
    else $error("search stack overflow");

  a_path_depth: assert property (@(posedge clk) disable iff (!rst_n)
    ($countones(on_path_r) == int'(sp_r)))
    else $error("on-path map disagrees with stack depth");

  a_abort_needs_loop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_abort_r || out_deadlock_r))
    else $error("victim reported without a deadlock");

  a_fin_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && out_valid_r && !out_ready |=> (state_r == S_FIN))
    else $error("result dropped while output register full");
`endif

endmodule
`default_nettype wire

FILE: design/wfg_mod.sv
// Iterative remainder unit: value modulo a small divisor, eight bits per cycle.
// Depends on wfg_pkg.
`default_nettype none
module wfg_mod
  import wfg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [TXN_W-1:0]  value,
  input  wire logic [TC_W-1:0]   divisor,
  output logic                   done,
  output logic [SLOT_W-1:0]      rem
);

  logic                 busy_r;
  logic                 done_r;
  logic [1:0]           cnt_r;
  logic [TXN_W-1:0]     val_r;
  logic [TC_W-1:0]      div_r;
  logic [TC_W-1:0]      rem_r;
  logic [TC_W-1:0]      rem_nxt;

  // restoring remainder over one digit; rem stays below the divisor
  always_comb begin
    rem_nxt = rem_r;
    for (int i = 0; i < MOD_DIGIT; i++) begin
      rem_nxt = {rem_nxt[TC_W-2:0], val_r[TXN_W-1-i]};
      if (rem_nxt >= div_r) begin
        rem_nxt = rem_nxt - div_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
      rem_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        val_r  <= value;
        div_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        val_r <= val_r << MOD_DIGIT;
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'(MOD_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r[SLOT_W-1:0];

endmodule
`default_nettype wire

FILE: bench/wfg_checker.sv
// Checker for the wait-for graph deadlock detector: watches the input, output and
// configuration channels, predicts each result from its own copy of the slot tables and compares.
// Depends on wfg_pkg.
module wfg_checker
  import wfg_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [1:0]        in_action,
  input  logic [TXN_W-1:0]  in_txn_id,
  input  logic [TXN_W-1:0]  in_target_txn,
  input  logic              in_has_target,
  input  logic [LOCK_W-1:0] in_lock_count,
  input  logic              out_valid,
  input  logic              out_ready,
  input  logic              out_status,
  input  logic              out_deadlock,
  input  logic              out_abort_valid,
  input  logic [TXN_W-1:0]  out_victim_txn,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [TC_W-1:0]   cfg_wdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic             status;
    logic             deadlock;
    logic             abort_valid;
    logic [TXN_W-1:0] victim;
  } verdict_t;

  verdict_t verdicts_due[$];

  logic [TC_W-1:0]   threads;
  logic              enabled;
  logic [TXN_W-1:0]  txn_tab   [MAX_THREADS];
  logic              live_tab  [MAX_THREADS];
  logic [LOCK_W-1:0] lock_tab  [MAX_THREADS];
  logic [TXN_W-1:0]  edges_tab [MAX_THREADS][MAX_EDGES];
  int                fill_tab  [MAX_THREADS];

  function automatic int slot_for(logic [TXN_W-1:0] id);
    int n;
    n = (threads == 0) ? 1 : (threads > MAX_THREADS) ? MAX_THREADS : int'(threads);
    return int'(id % n);
  endfunction

  function automatic bit holds(int s, logic [TXN_W-1:0] id);
    return live_tab[s] && txn_tab[s] == id;
  endfunction

  // Depth-first walk from the start id; pick the cheapest node on the loop.
  function automatic verdict_t search_cycle(logic [TXN_W-1:0] start);
    verdict_t          v;
    bit                seen [MAX_THREADS];
    bit                on_path [MAX_THREADS];
    int                stk_slot [MAX_THREADS];
    logic [TXN_W-1:0]  stk_id [MAX_THREADS];
    int                stk_next [MAX_THREADS];
    int                sp, top, s, ns, loop_head, s0;
    bit                loop, on_loop, head_set, victim_set;
    int                best;
    logic [TXN_W-1:0]  tgt, victim;
    v = '0;
    sp = 0; loop = 0; on_loop = 0; head_set = 0; victim_set = 0;
    loop_head = 0; best = LOCK_LIMIT; victim = '0;
    for (int i = 0; i < MAX_THREADS; i++) begin
      seen[i] = 0;
      on_path[i] = 0;
    end
    s0 = slot_for(start);
    seen[s0] = 1;
    if (holds(s0, start)) begin
      on_path[s0] = 1;
      stk_slot[0] = s0; stk_id[0] = start; stk_next[0] = 0; sp = 1;
    end
    while (sp > 0) begin
      top = sp - 1;
      s = stk_slot[top];
      if (loop || stk_next[top] >= fill_tab[s] || stk_next[top] >= MAX_EDGES) begin
        on_path[s] = 0;
        if (loop && on_loop && lock_tab[s] < best) begin
          best = lock_tab[s];
          victim = stk_id[top];
          victim_set = 1;
        end
        if (head_set && s == loop_head) on_loop = 0;
        sp = top;
      end else begin
        tgt = edges_tab[s][stk_next[top]];
        ns = slot_for(tgt);
        stk_next[top]++;
        if (on_path[ns] && holds(ns, tgt)) begin
          loop = 1; on_loop = 1; loop_head = ns; head_set = 1;
        end else if (!seen[ns] && holds(ns, tgt) && sp < MAX_THREADS) begin
          seen[ns] = 1; on_path[ns] = 1;
          stk_slot[sp] = ns; stk_id[sp] = tgt; stk_next[sp] = 0;
          sp++;
        end
      end
    end
    v.deadlock = loop;
    if (loop && victim_set) begin
      v.abort_valid = holds(slot_for(victim), victim);
      v.victim = victim;
    end
    return v;
  endfunction

  function automatic verdict_t apply_beat(logic [1:0] act, logic [TXN_W-1:0] id,
                                          logic [TXN_W-1:0] tgt, logic has_t,
                                          logic [LOCK_W-1:0] locks);
    verdict_t v;
    int s;
    v = '0;
    if (!enabled) return v;
    s = slot_for(id);
    case (act)
      ACT_ADD: begin
        txn_tab[s] = id;
        live_tab[s] = 1;
        lock_tab[s] = locks;
        if (has_t) begin
          if (fill_tab[s] < MAX_EDGES) begin
            edges_tab[s][fill_tab[s]] = tgt;
            fill_tab[s]++;
          end else begin
            v.status = 1;
          end
        end
      end
      ACT_CLEAR: begin
        live_tab[s] = 0;
        lock_tab[s] = '0;
        fill_tab[s] = 0;
      end
      ACT_DETECT: v = search_cycle(id);
      default: ;
    endcase
    return v;
  endfunction

  always @(posedge clk) begin
    verdict_t want;
    int       errs;
    errs = 0;
    if (!rst_n) begin
      threads <= TC_W'(MAX_THREADS);
      enabled <= 1'b1;
      fail_count <= 0;
      pending <= 0;
      verdicts_due.delete();
      for (int i = 0; i < MAX_THREADS; i++) begin
        live_tab[i] = 0;
        lock_tab[i] = '0;
        fill_tab[i] = 0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_THREAD_COUNT) threads <= cfg_wdata;
        else enabled <= cfg_wdata[0];
      end
      if (in_valid && in_ready)
        verdicts_due = {verdicts_due, apply_beat(in_action, in_txn_id, in_target_txn,
                                                 in_has_target, in_lock_count)};
      if (out_valid && out_ready) begin
        if (verdicts_due.size() == 0) begin
          $error("result beat with nothing expected");
          errs++;
        end else begin
          want = verdicts_due.pop_front();
          if (out_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_status);
            errs++;
          end
          if (out_deadlock !== want.deadlock) begin
            $error("deadlock: expected %0d, got %0d", want.deadlock, out_deadlock);
            errs++;
          end
          if (out_abort_valid !== want.abort_valid) begin
            $error("abort_valid: expected %0d, got %0d", want.abort_valid, out_abort_valid);
            errs++;
          end
          if (out_victim_txn !== want.victim) begin
            $error("victim_txn: expected %0h, got %0h", want.victim, out_victim_txn);
            errs++;
          end
        end
      end
      fail_count <= fail_count + errs;
      pending <= verdicts_due.size();
    end
  end

endmodule

FILE: bench/wait_for_graph_deadlock_detector_tb.sv
// Top of the bench for the wait-for graph deadlock detector: clock, reset,
// stimulus, configuration phases and the verdict. Depends on wfg_pkg, the detector and wfg_checker.
module wait_for_graph_deadlock_detector_tb;
  import wfg_pkg::*;

  logic              clk = 0;
  logic              rst_n = 0;
  logic              in_valid = 0;
  logic              in_ready;
  logic [1:0]        in_action = ACT_ADD;
  logic [TXN_W-1:0]  in_txn_id = '0;
  logic [TXN_W-1:0]  in_target_txn = '0;
  logic              in_has_target = 0;
  logic [LOCK_W-1:0] in_lock_count = '0;
  logic              out_valid;
  logic              out_ready = 0;
  logic              out_status, out_deadlock, out_abort_valid;
  logic [TXN_W-1:0]  out_victim_txn;
  logic              cfg_we = 0;
  logic              cfg_index = CFG_THREAD_COUNT;
  logic [TC_W-1:0]   cfg_wdata = '0;
  int                fail_count, pending;
  int                cycle_count = 0;
  bit                hold_off = 0;
  bit                no_gaps = 0;

  // Slowest run: ~600 beats, each up to a full-graph detect, plus stalls; take it several times over.
  localparam int CYCLE_LIMIT = 3_000_000;

  always #5 clk = ~clk;

  wait_for_graph_deadlock_detector dut (.*);

  wfg_checker chk (.*);

  // Hard stop on a hung handshake.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL wait_for_graph_deadlock_detector");
      $finish;
    end
  end

  // Receiver: random stalls per beat, plus one long hold-off on request.
  initial begin
    int gap;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_ready <= 0;
      end else begin
        gap = no_gaps ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
          out_ready <= 0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1;
        do @(posedge clk); while (!(out_valid && out_ready));
        out_ready <= 0;
      end
    end
  end

  // Offer one beat and hold it until accepted; valid drops when the next gap starts.
  task automatic send_beat(logic [1:0] act, logic [TXN_W-1:0] id,
                           logic [TXN_W-1:0] tgt, logic has_t, logic [LOCK_W-1:0] locks);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_action <= act;
    in_txn_id <= id;
    in_target_txn <= tgt;
    in_has_target <= has_t;
    in_lock_count <= locks;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // Drop valid, drain, let the sequencer settle, then write one register.
  task automatic write_reg(logic idx, logic [TC_W-1:0] val);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Random beat: ids drawn from a small pool so edges land on live slots.
  task automatic random_beat(int tc);
    logic [TXN_W-1:0] id, tgt;
    int r;
    id  = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 2 * tc + 1);
    tgt = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 2 * tc + 1);
    r = $urandom_range(0, 99);
    if (r < 55)
      send_beat(ACT_ADD, id, tgt, $urandom_range(0, 7) != 0,
                ($urandom_range(0, 3) == 0) ? LOCK_W'($urandom)
                                            : LOCK_W'($urandom_range(0, 1200)));
    else if (r < 68)
      send_beat(ACT_CLEAR, id, TXN_W'($urandom), 1'($urandom), LOCK_W'($urandom));
    else if (r < 97)
      send_beat(ACT_DETECT, id, TXN_W'($urandom), 1'($urandom), LOCK_W'($urandom));
    else
      send_beat(ACT_NONE, id, TXN_W'($urandom), 1'($urandom), LOCK_W'($urandom));
  endtask

  initial begin
    int tcs [6] = '{16, 1, 4, 0, 31, 7};
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: three-node loop, stale edge, full list, limits, odd action.
    send_beat(ACT_ADD, 32'd1, 32'd2, 1'b1, 16'd500);
    send_beat(ACT_ADD, 32'd2, 32'd3, 1'b1, 16'd300);
    send_beat(ACT_ADD, 32'd3, 32'd1, 1'b1, 16'd700);
    send_beat(ACT_DETECT, 32'd1, '0, 1'b0, '0);
    send_beat(ACT_ADD, 32'd2, 32'd3, 1'b0, 16'hFFFF);
    send_beat(ACT_ADD, 32'd3, 32'd1, 1'b0, 16'd1000);
    send_beat(ACT_ADD, 32'd1, 32'd2, 1'b0, 16'd999);
    send_beat(ACT_DETECT, 32'd2, '0, 1'b0, '0);
    send_beat(ACT_ADD, 32'd1, 32'd2, 1'b0, 16'd1000);
    send_beat(ACT_DETECT, 32'd3, '0, 1'b0, '0);
    send_beat(ACT_ADD, 32'd18, 32'hFFFF_FFFF, 1'b1, 16'd5);
    send_beat(ACT_DETECT, 32'd2, '0, 1'b0, '0);
    send_beat(ACT_DETECT, 32'hFFFF_FFFF, '0, 1'b0, '0);
    for (int i = 0; i < 9; i++)
      send_beat(ACT_ADD, 32'd5, 32'hAAAA_5555 + TXN_W'(i), 1'b1, '0);
    send_beat(ACT_CLEAR, 32'd5, '0, 1'b0, '0);
    send_beat(ACT_NONE, 32'd1, 32'd2, 1'b1, 16'd1);
    send_beat(ACT_DETECT, 32'd1, '0, 1'b0, '0);

    // Long hold-off: the sender keeps offering while results pile up.
    fork
      begin
        hold_off = 1;
        repeat (3000) @(posedge clk);
        hold_off = 0;
      end
      for (int i = 0; i < 8; i++) random_beat(16);
    join

    // Phases over thread counts and the enable, extremes included.
    foreach (tcs[p]) begin
      write_reg(CFG_THREAD_COUNT, TC_W'(tcs[p]));
      write_reg(CFG_DETECT_EN, (p == 2) ? '0 : TC_W'(1));
      no_gaps = (p == 1);
      for (int i = 0; i < 85; i++)
        random_beat((tcs[p] == 0) ? 1 : (tcs[p] > 16 ? 16 : tcs[p]));
    end
    write_reg(CFG_DETECT_EN, TC_W'(1));
    for (int i = 0; i < 10; i++) random_beat(16);

    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("PASS wait_for_graph_deadlock_detector");
    else $display("FAIL wait_for_graph_deadlock_detector");
    $finish;
  end

endmodule

FILE: sim.f
design/wfg_pkg.sv
design/wfg_mod.sv
design/wait_for_graph_deadlock_detector.sv
bench/wfg_checker.sv
bench/wait_for_graph_deadlock_detector_tb.sv
